[rtl/core/tim_pkg.sv]
// Shared types and constants of the TIM image stream parser.
package tim_pkg;

  localparam logic [7:0]  TIM_ID        = 8'h10;
  localparam logic [31:0] MIN_BLOCK_LEN = 32'd12;

  localparam logic [2:0] KIND_PAL_HDR = 3'd0;
  localparam logic [2:0] KIND_PIX_HDR = 3'd1;
  localparam logic [2:0] KIND_PAL_COL = 3'd2;
  localparam logic [2:0] KIND_INDEX   = 3'd3;
  localparam logic [2:0] KIND_DIRECT  = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_ID    = 3'd1;
  localparam logic [2:0] ERR_MODE      = 3'd2;
  localparam logic [2:0] ERR_SHORT     = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // Work classes handed from front to back.
  localparam logic [2:0] CMD_HDR    = 3'd0;
  localparam logic [2:0] CMD_COL15  = 3'd1;
  localparam logic [2:0] CMD_IDX4   = 3'd2;
  localparam logic [2:0] CMD_IDX8   = 3'd3;
  localparam logic [2:0] CMD_RGB24  = 3'd4;
  localparam logic [2:0] CMD_ERROR  = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        pal;
    logic [47:0] data;
    logic [63:0] hdr;
    logic [2:0]  mode;
    logic [2:0]  err;
  } tim_cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        stp;
    logic [15:0] org_x;
    logic [15:0] org_y;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  pixel_mode;
    logic [2:0]  error_code;
    logic        last;
  } tim_rec_t;

endpackage

[rtl/core/tim_front.sv]
// Byte parser: walks the file layout; one work command per completed unit or error.
module tim_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output tim_pkg::tim_cmd_t cmd
);
  import tim_pkg::*;

  localparam logic [3:0] PH_ID       = 4'd0;
  localparam logic [3:0] PH_ID_REST  = 4'd1;
  localparam logic [3:0] PH_FLAGS    = 4'd2;
  localparam logic [3:0] PH_PAL_LEN  = 4'd3;
  localparam logic [3:0] PH_PAL_HDR  = 4'd4;
  localparam logic [3:0] PH_PAL_DATA = 4'd5;
  localparam logic [3:0] PH_PIX_LEN  = 4'd6;
  localparam logic [3:0] PH_PIX_HDR  = 4'd7;
  localparam logic [3:0] PH_PIX_DATA = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic        palp_r, palp_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [39:0] unit_r, unit_nxt;
  logic [2:0]  ucnt_r, ucnt_nxt;

  logic        emit;
  tim_cmd_t    c;
  logic        take;

  // Effective state after an optional restart.
  logic [3:0]  ph;
  logic [2:0]  cnt, mode;
  logic        palp;
  logic [31:0] remain;
  logic [63:0] shift;
  logic [39:0] unit;
  logic [2:0]  ucnt;
  logic [63:0] shifted;
  logic [47:0] full;
  logic [2:0]  usize;
  logic        pal;
  logic [2:0]  cnt_inc, ucnt_inc;
  logic [31:0] rem_dec;

  assign in_ready = !cmd_valid || cmd_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (in_first_byte) begin
      ph = PH_ID; cnt = '0; mode = '0; palp = 1'b0;
      remain = '0; shift = '0; unit = '0; ucnt = '0;
    end else begin
      ph = phase_r; cnt = cnt_r; mode = mode_r; palp = palp_r;
      remain = remain_r; shift = shift_r; unit = unit_r; ucnt = ucnt_r;
    end
    phase_nxt = ph; cnt_nxt = cnt; mode_nxt = mode; palp_nxt = palp;
    remain_nxt = remain; shift_nxt = shift; unit_nxt = unit; ucnt_nxt = ucnt;
    emit = 1'b0;
    c = '0;
    cnt_inc = cnt + 3'd1;
    ucnt_inc = ucnt + 3'd1;
    shifted = shift | (64'(in_data_byte) << {cnt, 3'b000});
    full = {8'h00, unit} | (48'(in_data_byte) << {ucnt, 3'b000});
    pal = (ph == PH_PAL_DATA) || (ph == PH_PAL_HDR);
    rem_dec = (remain != '0) ? remain - 32'd1 : remain;
    if (pal)              usize = 3'd2;
    else if (mode == 3'd0) usize = 3'd1;
    else if (mode == 3'd3) usize = 3'd6;
    else                  usize = 3'd2;

    unique case (ph)
      PH_ID: begin
        if (in_data_byte != TIM_ID) begin
          emit = 1'b1; c.cmd = CMD_ERROR; c.err = ERR_BAD_ID; phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_ID_REST; cnt_nxt = '0; shift_nxt = '0;
        end
      end
      PH_ID_REST: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 3'd3) begin
          phase_nxt = PH_FLAGS; cnt_nxt = '0; shift_nxt = '0;
        end
      end
      PH_FLAGS: begin
        if (cnt == 3'd0) begin
          mode_nxt = in_data_byte[2:0];
          palp_nxt = in_data_byte[3];
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 3'd4) begin
          phase_nxt = palp_nxt ? PH_PAL_LEN : PH_PIX_LEN; cnt_nxt = '0; shift_nxt = '0;
        end
      end
      PH_PAL_LEN, PH_PIX_LEN: begin
        shift_nxt = shifted;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 3'd4) begin
          if (shifted[31:0] < MIN_BLOCK_LEN) begin
            emit = 1'b1; c.cmd = CMD_ERROR; c.err = ERR_SHORT; phase_nxt = PH_DONE;
          end else begin
            remain_nxt = shifted[31:0] - MIN_BLOCK_LEN;
            phase_nxt = (ph == PH_PAL_LEN) ? PH_PAL_HDR : PH_PIX_HDR;
            cnt_nxt = '0; shift_nxt = '0;
          end
        end
      end
      PH_PAL_HDR, PH_PIX_HDR: begin
        shift_nxt = shifted;
        cnt_nxt = cnt_inc;
        if (cnt == 3'd7) begin
          if (!pal && remain != '0 && mode[2]) begin
            emit = 1'b1; c.cmd = CMD_ERROR; c.err = ERR_MODE; phase_nxt = PH_DONE;
          end else begin
            emit = 1'b1; c.cmd = CMD_HDR; c.hdr = shifted;
            unit_nxt = '0; ucnt_nxt = '0;
            if (remain == '0) begin
              if (pal) begin
                phase_nxt = PH_PIX_LEN; cnt_nxt = '0; shift_nxt = '0;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt = pal ? PH_PAL_DATA : PH_PIX_DATA;
            end
          end
        end
      end
      PH_PAL_DATA, PH_PIX_DATA: begin
        remain_nxt = rem_dec;
        if (ucnt_inc < usize) begin
          unit_nxt = full[39:0]; ucnt_nxt = ucnt_inc;
        end else begin
          emit = 1'b1; c.data = full;
          if (pal || mode == 3'd2) c.cmd = CMD_COL15;
          else if (mode == 3'd0)   c.cmd = CMD_IDX4;
          else if (mode == 3'd1)   c.cmd = CMD_IDX8;
          else                     c.cmd = CMD_RGB24;
          unit_nxt = '0; ucnt_nxt = '0;
          if (rem_dec == '0) begin
            if (pal) begin
              phase_nxt = PH_PIX_LEN; cnt_nxt = '0; shift_nxt = '0;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
      default: phase_nxt = PH_DONE;
    endcase
    c.pal = pal;
    if (ph != PH_DONE && ph <= PH_PIX_DATA && in_last_byte && phase_nxt != PH_DONE) begin
      emit = 1'b1; c = '0; c.cmd = CMD_ERROR; c.err = ERR_TRUNCATED; phase_nxt = PH_DONE;
    end
    c.mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID; cnt_r <= '0; mode_r <= '0; palp_r <= 1'b0;
      remain_r <= '0; shift_r <= '0; unit_r <= '0; ucnt_r <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
      if (take) begin
        phase_r <= phase_nxt; cnt_r <= cnt_nxt; mode_r <= mode_nxt; palp_r <= palp_nxt;
        remain_r <= remain_nxt; shift_r <= shift_nxt; unit_r <= unit_nxt;
        ucnt_r <= ucnt_nxt;
        cmd_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) cmd <= c;
  end
endmodule

[rtl/core/tim_queue.sv]
// Two-entry queue carrying work commands from the parser to the record builder.
module tim_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  tim_pkg::tim_cmd_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output tim_pkg::tim_cmd_t rd_data
);
  import tim_pkg::*;

  tim_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

[rtl/core/tim_back.sv]
// Record builder: expands each work command into one or two result beats.
module tim_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tim_pkg::tim_cmd_t cmd,
  output logic              rec_valid,
  input  logic              rec_ready,
  output tim_pkg::tim_rec_t rec
);
  import tim_pkg::*;

  logic     second_r;
  logic     two;
  logic     fire;
  tim_rec_t r;

  assign two  = (cmd.cmd == CMD_IDX4) || (cmd.cmd == CMD_IDX8) || (cmd.cmd == CMD_RGB24);
  assign fire = cmd_valid && (!rec_valid || rec_ready);
  assign cmd_ready = fire && (!two || second_r);

  always_comb begin
    r = '0;
    r.pixel_mode = cmd.mode;
    r.last = !two || second_r;
    unique case (cmd.cmd)
      CMD_HDR: begin
        r.kind = cmd.pal ? KIND_PAL_HDR : KIND_PIX_HDR;
        r.org_x = cmd.hdr[15:0]; r.org_y = cmd.hdr[31:16];
        r.width = cmd.hdr[47:32]; r.height = cmd.hdr[63:48];
      end
      CMD_COL15: begin
        r.kind = cmd.pal ? KIND_PAL_COL : KIND_DIRECT;
        r.red = {3'b000, cmd.data[4:0]};
        r.green = {3'b000, cmd.data[9:5]};
        r.blue = {3'b000, cmd.data[14:10]};
        r.stp = cmd.data[15];
      end
      CMD_IDX4: begin
        r.kind = KIND_INDEX;
        r.red = second_r ? {4'h0, cmd.data[7:4]} : {4'h0, cmd.data[3:0]};
      end
      CMD_IDX8: begin
        r.kind = KIND_INDEX;
        r.red = second_r ? cmd.data[15:8] : cmd.data[7:0];
      end
      CMD_RGB24: begin
        r.kind = KIND_DIRECT;
        r.red   = second_r ? cmd.data[31:24] : cmd.data[7:0];
        r.green = second_r ? cmd.data[39:32] : cmd.data[15:8];
        r.blue  = second_r ? cmd.data[47:40] : cmd.data[23:16];
      end
      CMD_ERROR: begin
        r.kind = KIND_ERROR;
        r.error_code = cmd.err;
      end
      default: r.kind = KIND_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid <= 1'b0; second_r <= 1'b0;
    end else begin
      if (rec_valid && rec_ready) rec_valid <= 1'b0;
      if (fire) begin
        rec_valid <= 1'b1;
        second_r <= two && !second_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) rec <= r;
  end
endmodule

[rtl/core/tim_image_stream_parser.sv]
// Top level of the TIM image stream parser.
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_data_byte, in_first_byte, in_last_byte
//   out     | output    | out_valid, out_ready, out_kind .. out_last
// One byte is taken per cycle while in_ready is high; the parser registers a work
// command at the accepting edge, the queue takes it once it has room, and the record
// builder emits one beat per cycle while out_ready is high, two beats for two-record units.
// Each result passes the command register, a queue entry and the record register.
// Reset is synchronous on rst_n and returns the parser to the id byte.
// Output stalls fill the queue, then hold in_ready low.
module tim_image_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_stp,
  output logic [15:0] out_org_x,
  output logic [15:0] out_org_y,
  output logic [15:0] out_width,
  output logic [15:0] out_height,
  output logic [2:0]  out_pixel_mode,
  output logic [2:0]  out_error_code,
  output logic        out_last
);
  import tim_pkg::*;

  tim_cmd_t f_cmd, q_cmd;
  logic     f_valid, f_ready, q_valid, q_ready;
  tim_rec_t rec;

  tim_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_first_byte, .in_last_byte,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  tim_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  tim_back u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .rec_valid(out_valid), .rec_ready(out_ready), .rec(rec)
  );

  assign out_kind       = rec.kind;
  assign out_red        = rec.red;
  assign out_green      = rec.green;
  assign out_blue       = rec.blue;
  assign out_stp        = rec.stp;
  assign out_org_x      = rec.org_x;
  assign out_org_y      = rec.org_y;
  assign out_width      = rec.width;
  assign out_height     = rec.height;
  assign out_pixel_mode = rec.pixel_mode;
  assign out_error_code = rec.error_code;
  assign out_last       = rec.last;
endmodule
